### rtl/median_filter_3x3_defines.svh
// Assertion macros for the median filter RTL.
// All checks are clocked on i_clk and disabled while i_rst_n is low.
`ifndef MEDIAN_FILTER_3X3_DEFINES_SVH
`define MEDIAN_FILTER_3X3_DEFINES_SVH

// Same-cycle implication.
`define MF3_CHECK(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("median filter check failed");

// Next-cycle implication.
`define MF3_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("median filter check failed");

`endif

### rtl/mf3_pkg.sv
package mf3_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 8;
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int COLS      = 3;
    localparam int LINE_W    = 2 * PIX_W;

    localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = WIDTH_W'(640);
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = HEIGHT_W'(480);

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

    typedef logic [PIX_W-1:0] t_pix;

    typedef struct packed {
        t_pix lo;
        t_pix hi;
        t_pix med;
    } t_col;

    function automatic t_pix lo2(input t_pix x, input t_pix y);
        return (x < y) ? x : y;
    endfunction

    function automatic t_pix hi2(input t_pix x, input t_pix y);
        return (x > y) ? x : y;
    endfunction

    function automatic t_pix lo3(input t_pix x, input t_pix y, input t_pix z);
        return lo2(lo2(x, y), z);
    endfunction

    function automatic t_pix hi3(input t_pix x, input t_pix y, input t_pix z);
        return hi2(hi2(x, y), z);
    endfunction

    function automatic t_pix mid3(input t_pix x, input t_pix y, input t_pix z);
        return hi2(lo2(x, y), lo2(hi2(x, y), z));
    endfunction

endpackage

### rtl/mf3_ram.sv
module mf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mf3_cell.sv
module mf3_cell (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_shift,
    input  mf3_pkg::t_col i_col,
    output mf3_pkg::t_col o_col
);

    import mf3_pkg::*;

    t_col r_col;
    t_col n_col;

    always_comb begin
        n_col = r_col;
        if (i_shift) begin
            n_col = i_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

### rtl/median_filter_3x3.sv
// 3x3 median filter, one 8-bit pixel per clock in raster order. The line store
// (a 1024 x 16 RAM holding the two previous rows, read and written once per
// pixel) is read at the edge that accepts a pixel, and the column min/max/median
// reduction enters a chain of three column cells when the read stage moves on, so a
// median is on the output once its column reaches the cells. Sustained rate is one pixel
// per clock; a stalled output holds the cell chain and, once the read stage is
// also occupied, stalls the input. A median is produced for each pixel whose row
// and column are both two or more, giving a (width-2) x (height-2) output with
// row_end and frame_end marks. The line store starts with undefined contents;
// medians whose window touches never-written entries (only after a mid-frame
// width increase) are undefined. Configuration writes are always accepted and
// must only be issued while the block is idle.
`include "median_filter_3x3_defines.svh"

module median_filter_3x3 (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // pixel input
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [mf3_pkg::PIX_W-1:0]           i_pixel,
    // median output
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [mf3_pkg::PIX_W-1:0]           o_median,
    output logic                                o_row_end,
    output logic                                o_frame_end,
    // configuration write
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mf3_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mf3_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    import mf3_pkg::*;

    logic [WIDTH_W-1:0]  r_frame_width;
    logic [HEIGHT_W-1:0] r_frame_height;
    logic [ADDR_W-1:0]   r_col;
    logic [ADDR_W-1:0]   n_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [HEIGHT_W-1:0] n_row;

    logic [ADDR_W-1:0]   wm1;
    logic [HEIGHT_W-1:0] hm1;
    logic                last_col;
    logic                last_row;
    logic                has_res;

    logic                in_accept;
    logic                s2_free;
    logic                s1_move;

    logic                r_s1_valid;
    logic                r_s1_new;
    logic [ADDR_W-1:0]   r_s1_col;
    t_pix                r_s1_pix;
    logic                r_s1_res;
    logic                r_s1_row_end;
    logic                r_s1_frame_end;

    logic                r_s2_valid;
    logic                r_s2_res;
    logic                r_s2_row_end;
    logic                r_s2_frame_end;

    logic [LINE_W-1:0]   line_rdata;
    t_pix                top_pix;
    t_pix                mid_pix;
    t_col                new_col;
    t_col                col_d [COLS];
    t_col                col_q [COLS];

    // ---------------- configuration ----------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // effective last column / row, width clamped to 3..MAX_WIDTH, height to >= 3
    always_comb begin
        if (r_frame_width < WIDTH_W'(3)) begin
            wm1 = ADDR_W'(2);
        end else if (r_frame_width > WIDTH_W'(MAX_WIDTH)) begin
            wm1 = ADDR_W'(MAX_WIDTH - 1);
        end else begin
            wm1 = ADDR_W'(r_frame_width - WIDTH_W'(1));
        end
        if (r_frame_height < HEIGHT_W'(3)) begin
            hm1 = HEIGHT_W'(2);
        end else begin
            hm1 = r_frame_height - HEIGHT_W'(1);
        end
    end

    assign last_col = (r_col >= wm1);
    assign last_row = (r_row >= hm1);
    assign has_res  = (r_row >= HEIGHT_W'(2)) && (r_col >= ADDR_W'(2));

    // ---------------- handshake ----------------
    assign s2_free   = !r_s2_valid || !r_s2_res || !i_stall;
    assign s1_move   = r_s1_valid && s2_free;
    assign o_stall   = r_s1_valid && !s2_free;
    assign in_accept = i_valid && !o_stall;

    // ---------------- raster position ----------------
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (in_accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = r_col + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // ---------------- stage 1: line store read ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_new   <= 1'b0;
        end else begin
            r_s1_new <= in_accept;
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_col       <= r_col;
            r_s1_pix       <= i_pixel;
            r_s1_res       <= has_res;
            r_s1_row_end   <= last_col;
            r_s1_frame_end <= last_col && last_row;
        end
    end

    // entry holds {row above, two rows above}; write-back happens the cycle
    // after the read, so it never meets the next read address
    mf3_ram #(
        .WIDTH (LINE_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_new),
        .i_waddr (r_s1_col),
        .i_wdata ({r_s1_pix, line_rdata[LINE_W-1:PIX_W]}),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (line_rdata)
    );

    assign mid_pix = line_rdata[LINE_W-1:PIX_W];
    assign top_pix = line_rdata[PIX_W-1:0];

    always_comb begin
        new_col.lo  = lo3(top_pix, mid_pix, r_s1_pix);
        new_col.hi  = hi3(top_pix, mid_pix, r_s1_pix);
        new_col.med = mid3(top_pix, mid_pix, r_s1_pix);
    end

    // ---------------- column cell chain ----------------
    assign col_d[COLS-1] = new_col;

    for (genvar gi = 0; gi < COLS; gi++) begin : g_cell
        if (gi < COLS - 1) begin : g_link
            assign col_d[gi] = col_q[gi+1];
        end
        mf3_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (s1_move),
            .i_col   (col_d[gi]),
            .o_col   (col_q[gi])
        );
    end

    // ---------------- stage 2: output ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_move) begin
            r_s2_valid <= 1'b1;
        end else if (s2_free) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_s2_res       <= r_s1_res;
            r_s2_row_end   <= r_s1_row_end;
            r_s2_frame_end <= r_s1_frame_end;
        end
    end

    // cells hold still while the output is stalled
    assign o_valid     = r_s2_valid && r_s2_res;
    assign o_row_end   = r_s2_row_end;
    assign o_frame_end = r_s2_frame_end;
    assign o_median    = mid3(hi3(col_q[0].lo, col_q[1].lo, col_q[2].lo),
                              lo3(col_q[0].hi, col_q[1].hi, col_q[2].hi),
                              mid3(col_q[0].med, col_q[1].med, col_q[2].med));

    // ---------------- checks ----------------
    `MF3_CHECK(a_ram_no_collide, r_s1_new && in_accept, r_col != r_s1_col)
    `MF3_CHECK(a_frame_end_row_end, o_valid && o_frame_end, o_row_end)
    `MF3_CHECK(a_stall_needs_s1, o_stall, r_s1_valid)
    `MF3_CHECK_NEXT(a_accept_loads_s1, in_accept, r_s1_valid && r_s1_new)

endmodule

### test/tb_median_filter_3x3.sv
`timescale 1ns / 1ps

module tb_median_filter_3x3;
    import mf3_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 3;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int RANDOM_TARGET = 700;
    localparam int IDLE_PCT      = 28;
    localparam int MAX_REPORTS   = 10;
    localparam int TIMEOUT_NS    = 2_000_000;
    localparam int N_DIRECTED    = 20;

    typedef struct packed {
        t_pix median;
        logic row_end;
        logic frame_end;
    } t_median_out;

    typedef enum logic {DIR_PIXEL, DIR_REG} t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DAT_W-1:0]   value;
        logic                   has_exp;
        t_median_out            exp;
    } t_dir_row;

    localparam t_median_out NO_RESULT = '0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    t_pix                   i_pixel = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    t_pix                   o_median;
    logic                   o_row_end;
    logic                   o_frame_end;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]   i_cfg_data = '0;

    median_filter_3x3 uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_pixel     (i_pixel),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_median    (o_median),
        .o_row_end   (o_row_end),
        .o_frame_end (o_frame_end),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // predictor state
    t_pix                line_up  [MAX_WIDTH];
    t_pix                line_up2 [MAX_WIDTH];
    t_pix                col_lo   [COLS];
    t_pix                col_hi   [COLS];
    t_pix                col_med  [COLS];
    int                  col_pos;
    logic [HEIGHT_W-1:0] row_pos;
    logic [WIDTH_W-1:0]  cfg_width;
    logic [HEIGHT_W-1:0] cfg_height;

    t_median_out expected_medians[$];
    int          error_count = 0;
    int          random_pixels = 0;
    bit          calm = 1'b0;

    // typed expectation carried along with the pixel being offered
    logic        dir_has_exp = 1'b0;
    t_median_out dir_exp = '0;

    int hold_left = 0;
    int holds_begun = 0;
    int holds_asked = 0;

    // extremes, ties and register saturation; each 3x3 frame gives one median
    t_dir_row directed [N_DIRECTED] = '{
        '{DIR_REG,   REG_FRAME_WIDTH,  16'd2,   1'b0, NO_RESULT},
        '{DIR_REG,   REG_FRAME_HEIGHT, 16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b1, '{8'd0, 1'b1, 1'b1}},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd0,   1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b0, NO_RESULT},
        '{DIR_PIXEL, REG_FRAME_WIDTH,  16'd255, 1'b1, '{8'd255, 1'b1, 1'b1}}
    };

    function automatic t_pix pick_lo(input t_pix a, input t_pix b);
        return (b < a) ? b : a;
    endfunction

    function automatic t_pix pick_hi(input t_pix a, input t_pix b);
        return (b > a) ? b : a;
    endfunction

    // middle of three = sum minus the two outer values
    function automatic t_pix pick_mid(input t_pix a, input t_pix b, input t_pix c);
        int sum;
        sum = int'(a) + int'(b) + int'(c);
        sum = sum - int'(pick_lo(pick_lo(a, b), c)) - int'(pick_hi(pick_hi(a, b), c));
        return t_pix'(sum);
    endfunction

    function automatic int eff_width();
        if (cfg_width < 3) return 3;
        if (cfg_width > MAX_WIDTH) return MAX_WIDTH;
        return int'(cfg_width);
    endfunction

    function automatic int eff_height();
        return (cfg_height < 3) ? 3 : int'(cfg_height);
    endfunction

    function automatic void reset_predictor();
        foreach (line_up[k]) begin
            line_up[k]  = '0;
            line_up2[k] = '0;
        end
        foreach (col_lo[k]) begin
            col_lo[k]  = '0;
            col_hi[k]  = '0;
            col_med[k] = '0;
        end
        col_pos    = 0;
        row_pos    = '0;
        cfg_width  = RST_FRAME_WIDTH;
        cfg_height = RST_FRAME_HEIGHT;
    endfunction

    function automatic void filter_step(input t_pix px, output bit produced,
                                        output t_median_out res);
        int   w;
        int   h;
        t_pix up2;
        t_pix up;
        bit   last_col;
        bit   last_row;
        w        = eff_width();
        h        = eff_height();
        last_col = col_pos >= w - 1;
        last_row = int'(row_pos) >= h - 1;
        up2 = line_up2[col_pos];
        up  = line_up[col_pos];
        line_up2[col_pos] = up;
        line_up[col_pos]  = px;
        for (int k = 0; k < COLS - 1; k++) begin
            col_lo[k]  = col_lo[k+1];
            col_hi[k]  = col_hi[k+1];
            col_med[k] = col_med[k+1];
        end
        col_lo[COLS-1]  = pick_lo(pick_lo(up2, up), px);
        col_hi[COLS-1]  = pick_hi(pick_hi(up2, up), px);
        col_med[COLS-1] = pick_mid(up2, up, px);
        produced = (row_pos >= 2) && (col_pos >= 2);
        res.median = pick_mid(pick_hi(pick_hi(col_lo[0], col_lo[1]), col_lo[2]),
                              pick_lo(pick_lo(col_hi[0], col_hi[1]), col_hi[2]),
                              pick_mid(col_med[0], col_med[1], col_med[2]));
        res.row_end   = last_col;
        res.frame_end = last_col && last_row;
        if (last_col) begin
            col_pos = 0;
            row_pos = last_row ? '0 : row_pos + HEIGHT_W'(1);
        end else begin
            col_pos = col_pos + 1;
        end
    endfunction

    function automatic int pixels_to_frame_start();
        int w;
        int h;
        int n;
        w = eff_width();
        h = eff_height();
        if (col_pos == 0 && row_pos == 0) return 0;
        n = (col_pos >= w - 1) ? 1 : w - col_pos;
        if (int'(row_pos) >= h - 1) return n;
        return n + (h - 1 - int'(row_pos)) * w;
    endfunction

    function automatic t_pix rand_pixel();
        case ($urandom_range(3))
            0:       return $urandom_range(1) ? 8'hFF : 8'h00;
            1:       return t_pix'($urandom_range(120, 135));  // plenty of ties
            default: return t_pix'($urandom);
        endcase
    endfunction

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // predictor and scoreboard, all on sampled values of one edge
    always @(posedge i_clk) begin : monitor
        t_median_out want;
        t_median_out seen;
        bit          produced;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_FRAME_WIDTH) cfg_width = i_cfg_data[WIDTH_W-1:0];
                else if (i_cfg_index == REG_FRAME_HEIGHT) cfg_height = i_cfg_data;
            end
            if (i_valid && !o_stall) begin
                filter_step(i_pixel, produced, want);
                if (dir_has_exp) expected_medians.push_back(dir_exp);
                else if (produced) expected_medians.push_back(want);
            end
            if (o_valid && !i_stall) begin
                seen.median    = o_median;
                seen.row_end   = o_row_end;
                seen.frame_end = o_frame_end;
                if (expected_medians.size() == 0) begin
                    note_error($sformatf("unexpected median %0d row_end %b frame_end %b",
                                         seen.median, seen.row_end, seen.frame_end));
                end else begin
                    want = expected_medians.pop_front();
                    if (seen.median !== want.median || seen.row_end !== want.row_end ||
                        seen.frame_end !== want.frame_end)
                        note_error($sformatf(
                            "median mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                            want.median, want.row_end, want.frame_end,
                            seen.median, seen.row_end, seen.frame_end));
                end
            end
        end
    end

    // output side: random stalls plus requested long hold-offs
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (holds_begun != holds_asked) begin
            holds_begun <= holds_begun + 1;
            hold_left   <= HOLD_CYCLES - 1;
            i_stall     <= 1'b1;
        end else begin
            i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // valid stays up across back-to-back transactions; lowered for a gap or by drain()
    task automatic send_pixel(input t_pix px, input logic has_exp, input t_median_out exp);
        int gap;
        gap = 0;
        if (!calm) begin
            while ($urandom_range(99) < IDLE_PCT) gap++;
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_pixel     <= px;
        dir_has_exp <= has_exp;
        dir_exp     <= exp;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(rand_pixel(), 1'b0, NO_RESULT);
        random_pixels += n;
    endtask

    task automatic finish_frame();
        send_random(pixels_to_frame_start());
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_medians.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // drains first; after the write it waits so the predictor has taken it in
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        int n;
        int cut;
        reset_predictor();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[k]) begin
            if (directed[k].kind == DIR_REG)
                write_reg(directed[k].reg_index, directed[k].value);
            else
                send_pixel(directed[k].value[PIX_W-1:0], directed[k].has_exp, directed[k].exp);
        end

        // back-pressure: no idling, output held off while pixels keep coming
        write_reg(REG_FRAME_WIDTH, CFG_DAT_W'(8));
        write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(40));
        calm = 1'b1;
        holds_asked++;
        send_random(8 * 40);
        calm = 1'b0;

        // widest line (register saturates), then narrowed mid-frame
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(3));
        send_random(2 * MAX_WIDTH + 5);
        write_reg(REG_FRAME_WIDTH, CFG_DAT_W'(3));
        finish_frame();

        // tallest frame, cut short by a mid-frame height write
        write_reg(REG_FRAME_HEIGHT, '1);
        send_random(3 * 12);
        write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'(5));
        finish_frame();

        random_pixels = 0;
        while (random_pixels < RANDOM_TARGET) begin
            write_reg(REG_FRAME_WIDTH, CFG_DAT_W'($urandom_range(0, 24)));
            write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'($urandom_range(0, 8)));
            calm = ($urandom_range(9) == 0);
            n = eff_width() * eff_height() * int'($urandom_range(1, 2));
            if ($urandom_range(3) == 0) begin
                cut = $urandom_range(1, n - 1);
                send_random(cut);
                // width may only shrink mid-frame, else unwritten line entries get read
                if ($urandom_range(1))
                    write_reg(REG_FRAME_HEIGHT, CFG_DAT_W'($urandom_range(0, 12)));
                else
                    write_reg(REG_FRAME_WIDTH, CFG_DAT_W'($urandom_range(0, eff_width())));
                finish_frame();
            end else begin
                send_random(n);
            end
        end
        calm = 1'b0;

        drain();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/mf3_pkg.sv
rtl/mf3_ram.sv
rtl/mf3_cell.sv
rtl/median_filter_3x3.sv
test/tb_median_filter_3x3.sv
